/* rtl/ost_pkg.sv */
// Shared constants, types and control bundle for the ordered set table.
package ost_pkg;

    // Table geometry
    localparam int CAPACITY = 16;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // Field widths of the item formats
    localparam int OP_W    = 2;
    localparam int VALUE_W = 32;
    localparam int POS_W   = 5;

    // Operation codes
    localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;

    typedef logic signed [VALUE_W-1:0] value_t;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;  // latch the input item and its match vector
        logic commit;   // apply the operation and load the result register
    } ost_cmd_t;

endpackage

/* rtl/ost_ctrl.sv */
// Controller state machine for the ordered set table: handshakes and sequencing.
module ost_ctrl
    import ost_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    output logic     s_tready,
    output logic     m_tvalid,
    input  logic     m_tready,
    output ost_cmd_t cmd
);

    typedef enum logic [1:0] {
        ST_IDLE   = 2'b01,
        ST_UPDATE = 2'b10
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    // Next state and commands
    always_comb begin
        state_next  = state_reg;
        cmd.capture = 1'b0;
        cmd.commit  = 1'b0;
        s_tready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                // wait until the result register is free or being emptied
                if (!out_valid_reg || m_tready) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Result register occupancy
    always_comb begin
        out_valid_next = out_valid_reg;
        if (m_tready) begin
            out_valid_next = 1'b0;
        end
        if (cmd.commit) begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;

    // A commit never overwrites a result that is still waiting
    a_commit_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |-> (!out_valid_reg || m_tready))
        else $error("commit while result register busy");

    // A captured item is always followed by its update step
    a_capture_then_update: assert property (@(posedge aclk) disable iff (!aresetn)
        (aresetn && cmd.capture) |=> (state_reg == ST_UPDATE))
        else $error("capture not followed by update");

endmodule

/* rtl/ost_datapath.sv */
// Datapath for the ordered set table: entry store, parallel compare, shift, result.
module ost_datapath
    import ost_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  ost_cmd_t         cmd,
    input  logic [OP_W-1:0]  in_operation,
    input  value_t           in_value,
    output logic             out_ok,
    output logic [POS_W-1:0] out_position,
    output logic [POS_W-1:0] out_count
);

    value_t              entries_reg [CAPACITY];
    value_t              entries_next [CAPACITY];
    logic [CNT_W-1:0]    held_reg, held_next;
    logic [OP_W-1:0]     op_reg;
    value_t              value_reg;
    logic [CAPACITY-1:0] match_reg, match_next;
    logic [IDX_W-1:0]    hit_idx;
    logic                hit;
    logic                do_add, do_remove, ok_next;
    logic [POS_W-1:0]    pos_next;
    logic                ok_reg;
    logic [POS_W-1:0]    pos_reg, cnt_reg;

    // Compare the incoming value against every valid entry
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            match_next[i] = (entries_reg[i] == in_value) && (CNT_W'(i) < held_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg    <= in_operation;
            value_reg <= in_value;
            match_reg <= match_next;
        end
    end

    // Hit position: entries are distinct, so at most one bit is set
    always_comb begin
        hit_idx = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            hit_idx = hit_idx | (match_reg[i] ? IDX_W'(i) : IDX_W'(0));
        end
        hit = |match_reg;
    end

    // Decide the operation outcome
    always_comb begin
        do_add    = (op_reg == OP_ADD) && !hit && (held_reg < CNT_W'(CAPACITY));
        do_remove = (op_reg == OP_REMOVE) && hit;
        ok_next   = do_add || do_remove || ((op_reg == OP_LOOKUP) && hit);
        pos_next  = '0;
        if ((op_reg == OP_LOOKUP) && hit) begin
            pos_next = POS_W'(hit_idx) + POS_W'(1);
        end
    end

    // Shift entries back for an add, forward behind the hit for a remove
    always_comb begin
        entries_next = entries_reg;
        held_next    = held_reg;
        if (do_add) begin
            entries_next[0] = value_reg;
            for (int i = 1; i < CAPACITY; i++) begin
                entries_next[i] = entries_reg[i-1];
            end
            held_next = held_reg + CNT_W'(1);
        end else if (do_remove) begin
            for (int i = 0; i < CAPACITY - 1; i++) begin
                if (IDX_W'(i) >= hit_idx) begin
                    entries_next[i] = entries_reg[i+1];
                end
            end
            held_next = held_reg - CNT_W'(1);
        end
    end

    // Entry store has no reset; only entries below the count are read
    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            for (int i = 0; i < CAPACITY; i++) begin
                entries_reg[i] <= entries_next[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg <= '0;
        end else if (cmd.commit) begin
            held_reg <= held_next;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            ok_reg  <= ok_next;
            pos_reg <= pos_next;
            cnt_reg <= POS_W'(held_next);
        end
    end

    assign out_ok       = ok_reg;
    assign out_position = pos_reg;
    assign out_count    = cnt_reg;

    // Count never exceeds the table size
    a_held_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        held_reg <= CNT_W'(CAPACITY))
        else $error("held count above capacity");

    // A successful add grows the count by one
    a_add_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (aresetn && cmd.commit && do_add) |=> (held_reg == $past(held_reg) + CNT_W'(1)))
        else $error("add did not grow count");

    // Count changes only on a commit
    a_held_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        (aresetn && !cmd.commit) |=> $stable(held_reg))
        else $error("count changed without commit");

endmodule

/* rtl/ordered_set_table_top.sv */
// Top level of the ordered set table: controller, datapath and stream ports.
//
//  channel | dir | tdata (low bit up)                      | tuser
//  s_      | in  | value[31:0]                             | operation[1:0]
//  m_      | out | ok[0], position[5:1], count[10:6], zero | none
//
// Each item passes through an accept state that compares the value
// against all entries in parallel, and an update state that shifts the
// entry registers and loads the result register.
// The update waits while the result register is full and m_tready is low.
// aresetn is synchronous, active low; it clears the count and handshake
// state, leaving the entry store unwritten.
module ordered_set_table_top
    import ost_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // value[31:0]
    input  logic [1:0]  s_tuser,   // operation[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // ok[0], position[5:1], count[10:6], zero[15:11]
);

    ost_cmd_t         cmd;
    logic             res_ok;
    logic [POS_W-1:0] res_position;
    logic [POS_W-1:0] res_count;

    ost_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    ost_datapath u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .in_operation (s_tuser),
        .in_value     (value_t'(s_tdata)),
        .out_ok       (res_ok),
        .out_position (res_position),
        .out_count    (res_count)
    );

    // Pack the result item
    assign m_tdata = {5'b0, res_count, res_position, res_ok};

endmodule

/* dv/tb_ordered_set_table_top.sv */
// Self-checking testbench for the ordered set table: directed and random item traffic.
`timescale 1ns / 1ps

module tb_ordered_set_table_top;
    import ost_pkg::*;

    // Op code 3 has no meaning; the block must answer it without touching the set
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int STALL_LIMIT = 2000;
    localparam int POOL_SIZE   = 24;
    localparam int TAIL_CYCLES = 8;

    typedef struct packed {
        logic             ok;
        logic [POS_W-1:0] position;
        logic [4:0]       count;
    } reply_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;   // value[31:0]
    logic [1:0]  s_tuser  = '0;   // operation[1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;         // ok[0], position[5:1], count[10:6], zero[15:11]

    // Shadow copy of the set, newest first
    value_t set_entries [CAPACITY];
    int     set_held = 0;
    value_t value_pool [POOL_SIZE];

    reply_t table_replies_q [$];
    int     err_count   = 0;
    int     idle_cycles = 0;
    int     send_gap_max  = 3;
    int     sink_stall_max = 3;

    ordered_set_table_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #4 aclk = ~aclk;

    // Applies one operation to the shadow set and returns the reply it produces
    function automatic reply_t apply_table_op(logic [OP_W-1:0] op, value_t v);
        reply_t r;
        int     hit;
        r   = '0;
        hit = -1;
        for (int i = 0; i < set_held; i++) begin
            if (hit < 0 && set_entries[i] == v) hit = i;
        end
        case (op)
            OP_ADD: begin
                if (hit < 0 && set_held < CAPACITY) begin
                    for (int i = set_held; i > 0; i--) set_entries[i] = set_entries[i-1];
                    set_entries[0] = v;
                    set_held++;
                    r.ok = 1'b1;
                end
            end
            OP_REMOVE: begin
                if (hit >= 0) begin
                    // close the gap behind the removed entry
                    for (int i = hit; i + 1 < set_held; i++) set_entries[i] = set_entries[i+1];
                    set_held--;
                    r.ok = 1'b1;
                end
            end
            OP_LOOKUP: begin
                if (hit >= 0) begin
                    r.ok       = 1'b1;
                    r.position = POS_W'(hit + 1);
                end
            end
            default: ;
        endcase
        r.count = 5'(set_held);
        return r;
    endfunction

    // Drives one item, waits for its handshake and records the reply it should get
    task automatic send_item(logic [OP_W-1:0] op, value_t v);
        int gap;
        gap = $urandom_range(0, send_gap_max);
        repeat (gap) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        s_tuser  <= op;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        table_replies_q.push_back(apply_table_op(op, v));
    endtask

    // Mostly values already held or from a small pool, so hits are common
    function automatic value_t pick_value(int held_pct);
        if (set_held > 0 && $urandom_range(0, 99) < held_pct)
            return set_entries[$urandom_range(0, set_held - 1)];
        if ($urandom_range(0, 9) == 0)
            return value_t'($urandom);
        return value_pool[$urandom_range(0, POOL_SIZE - 1)];
    endfunction

    // Lookup, remove and the unused code on an empty set
    task automatic test_empty_table();
        send_item(OP_LOOKUP, 32'sd5);
        send_item(OP_REMOVE, 32'sd5);
        send_item(OP_UNUSED, -32'sd1);
    endtask

    // Extreme and alternating bit patterns, a duplicate add and a deep lookup
    task automatic test_extreme_values();
        send_item(OP_ADD, 32'h8000_0000);
        send_item(OP_ADD, 32'h7FFF_FFFF);
        send_item(OP_ADD, 32'hAAAA_AAAA);
        send_item(OP_ADD, 32'h5555_5555);
        send_item(OP_ADD, 32'h7FFF_FFFF);
        send_item(OP_LOOKUP, 32'h8000_0000);
    endtask

    // Fill to capacity, add when full, look up the oldest, remove from the middle, miss and send the unused code
    task automatic test_full_table();
        for (int i = 0; set_held < CAPACITY; i++) send_item(OP_ADD, value_t'(i * 3 - 7));
        send_item(OP_ADD, 32'sd1000);
        send_item(OP_LOOKUP, set_entries[CAPACITY-1]);
        send_item(OP_REMOVE, set_entries[CAPACITY/2]);
        send_item(OP_REMOVE, 32'sd1000);
        send_item(OP_UNUSED, set_entries[0]);
    endtask

    // Random traffic; add_pct steers the set toward full or toward empty
    task automatic test_random_traffic(int n_items, int add_pct, int gap_max);
        int               r;
        logic [OP_W-1:0]  op;
        send_gap_max   = gap_max;
        sink_stall_max = gap_max;
        for (int i = 0; i < POOL_SIZE; i++) value_pool[i] = value_t'($urandom);
        value_pool[0] = 32'h8000_0000;
        value_pool[1] = 32'h7FFF_FFFF;
        value_pool[2] = '0;
        value_pool[3] = -32'sd1;
        for (int i = 0; i < n_items; i++) begin
            r = $urandom_range(0, 99);
            if (r < 2)
                op = OP_UNUSED;
            else if (r < 2 + add_pct)
                op = OP_ADD;
            else if ($urandom_range(0, 4) < 3)
                op = OP_REMOVE;
            else
                op = OP_LOOKUP;
            send_item(op, pick_value(op == OP_ADD ? 12 : 50));
        end
    endtask

    // Result side: random stalls, then check each reply against the oldest prediction
    initial begin : reply_sink
        int     stall;
        reply_t want;
        reply_t got;
        while (!aresetn) @(negedge aclk);
        forever begin
            stall = $urandom_range(0, sink_stall_max);
            repeat (stall) begin
                @(negedge aclk);
                m_tready <= 1'b0;
            end
            @(negedge aclk);
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            got.ok       = m_tdata[0];
            got.position = m_tdata[5:1];
            got.count    = m_tdata[10:6];
            if (table_replies_q.size() == 0) begin
                err_count++;
                if (err_count <= 10)
                    $display("unexpected reply: ok=%0d pos=%0d count=%0d",
                             got.ok, got.position, got.count);
            end else begin
                want = table_replies_q.pop_front();
                if (got !== want) begin
                    err_count++;
                    if (err_count <= 10)
                        $display("mismatch ok/pos/count: want %0d/%0d/%0d got %0d/%0d/%0d",
                                 want.ok, want.position, want.count,
                                 got.ok, got.position, got.count);
                end
            end
        end
    end

    // Watchdog: too long without any handshake on either side
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("tb_ordered_set_table_top: done, errors");
            $finish;
        end
    end

    initial begin
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_empty_table();
        test_extreme_values();
        test_full_table();
        test_random_traffic(250, 70, 3);
        test_random_traffic(250, 20, 3);
        test_random_traffic(250, 70, 0);
        test_random_traffic(250, 40, 3);
        test_random_traffic(250, 75, 1);
        test_random_traffic(250, 15, 3);
        test_random_traffic(250, 45, 3);

        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (table_replies_q.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (err_count == 0)
            $display("tb_ordered_set_table_top: done, clean");
        else
            $display("tb_ordered_set_table_top: done, errors");
        $finish;
    end

endmodule

/* filelist.f */
rtl/ost_pkg.sv
rtl/ost_ctrl.sv
rtl/ost_datapath.sv
rtl/ordered_set_table_top.sv
dv/tb_ordered_set_table_top.sv
